FILE: rtl/core/tsp_pkg.sv
package tsp_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int POSITION_SCALE_DEF = 127;

  // Slider geometry and fixed field widths
  localparam int NUM_CH = 3;
  localparam int CH_W   = 2;
  localparam int POS_W  = 8;

  // Fixed part of a queue entry: press mask, round-done flag, next channel
  localparam int ENT_FIXED_W = NUM_CH + 1 + CH_W;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Threshold reset values
  localparam int DOWN_THR_RESET = 2000;
  localparam int UP_THR_RESET   = 500;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE_CH0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE_CH1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE_CH2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP_THRESHOLD   = 3'd4;

  // Scan channel codes
  localparam logic [CH_W-1:0] CH0 = 2'd0;
  localparam logic [CH_W-1:0] CH1 = 2'd1;
  localparam logic [CH_W-1:0] CH2 = 2'd2;

endpackage

FILE: rtl/core/tsp_if.sv
// Sample channel: one touch reading per transfer
interface tsp_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Result channel: one result per accepted sample
interface tsp_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic signed [7:0]      position;
  logic [2:0]             press_mask;
  logic                   position_updated;
  logic [1:0]             next_channel;
  logic [SAMPLE_BITS-1:0] channel_drop;

  modport source (output valid, output position, output press_mask,
                  output position_updated, output next_channel,
                  output channel_drop, input ready);
  modport sink   (input valid, input position, input press_mask,
                  input position_updated, input next_channel,
                  input channel_drop, output ready);
endinterface

FILE: rtl/core/tsp_fifo.sv
module tsp_fifo
  import tsp_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             wr_ready,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             rd_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/core/tsp_front.sv
module tsp_front
  import tsp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  tsp_in_if.sink                                 in_ch,
  input  logic                                   cfg_we,
  input  logic [CFG_IDX_W-1:0]                   cfg_idx,
  input  logic [SAMPLE_BITS-1:0]                 cfg_data,
  output logic                                   q_push,
  output logic [3*SAMPLE_BITS+ENT_FIXED_W-1:0]   q_data,
  input  logic                                   q_ready
);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] drop;
    logic [SAMPLE_BITS-1:0] d0;
    logic [SAMPLE_BITS-1:0] d1;
    logic [NUM_CH-1:0]      mask;
    logic                   done;
    logic [CH_W-1:0]        next_ch;
  } tsp_ent_t;

  logic [SAMPLE_BITS-1:0] base_r [NUM_CH];
  logic [SAMPLE_BITS-1:0] down_thr_r;
  logic [SAMPLE_BITS-1:0] up_thr_r;
  logic [CH_W-1:0]        scan_r;
  logic [NUM_CH-1:0]      flags_r;
  logic [SAMPLE_BITS-1:0] drops_r [NUM_CH];

  logic [SAMPLE_BITS-1:0] base;
  logic [SAMPLE_BITS-1:0] drop;
  logic [NUM_CH-1:0]      ch_bit;
  logic [NUM_CH-1:0]      flags_nxt;
  logic                   done;
  logic [CH_W-1:0]        scan_nxt;
  tsp_ent_t               ent;

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready;

  // Baseline of the channel being scanned
  always_comb begin
    unique case (scan_r)
      CH0:     base = base_r[0];
      CH1:     base = base_r[1];
      default: base = base_r[2];
    endcase
  end

  // Drop below baseline, floored at zero
  assign drop = (base > in_ch.sample) ? base - in_ch.sample : '0;

  // Press hysteresis: release test first
  assign ch_bit = NUM_CH'(1) << scan_r;
  always_comb begin
    flags_nxt = flags_r;
    if (drop < up_thr_r) begin
      flags_nxt = flags_r & ~ch_bit;
    end else if (drop > down_thr_r) begin
      flags_nxt = flags_r | ch_bit;
    end
  end

  assign done     = (scan_r == CH2);
  assign scan_nxt = done ? CH0 : scan_r + 1'b1;

  // Queue entry; the closing sample supplies the channel 2 drop itself
  always_comb begin
    ent.drop    = drop;
    ent.d0      = drops_r[0];
    ent.d1      = drops_r[1];
    ent.mask    = flags_nxt;
    ent.done    = done;
    ent.next_ch = scan_nxt;
  end
  assign q_data = ent;

  // Scan state, press flags and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r     <= CH0;
      flags_r    <= '0;
      base_r[0]  <= '0;
      base_r[1]  <= '0;
      base_r[2]  <= '0;
      down_thr_r <= SAMPLE_BITS'(DOWN_THR_RESET);
      up_thr_r   <= SAMPLE_BITS'(UP_THR_RESET);
    end else begin
      if (q_push) begin
        scan_r  <= scan_nxt;
        flags_r <= flags_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_BASELINE_CH0:   base_r[0]  <= cfg_data;
          REG_BASELINE_CH1:   base_r[1]  <= cfg_data;
          REG_BASELINE_CH2:   base_r[2]  <= cfg_data;
          REG_DOWN_THRESHOLD: down_thr_r <= cfg_data;
          REG_UP_THRESHOLD:   up_thr_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Per-channel drop store, written before it is read in each round
  always_ff @(posedge clk) begin
    if (q_push) begin
      unique case (scan_r)
        CH0:     drops_r[0] <= drop;
        CH1:     drops_r[1] <= drop;
        default: drops_r[2] <= drop;
      endcase
    end
  end

endmodule

FILE: rtl/core/tsp_div.sv
module tsp_div #(
  parameter int W = 18
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     dvs_r;

  logic [W:0]       shifted;
  logic             ge;
  logic [W-1:0]     rem_nxt;

  assign done     = done_r;
  assign quotient = quo_r;

  // One restoring step per cycle
  assign shifted = {rem_r, quo_r[W-1]};
  assign ge      = (shifted >= {1'b0, dvs_r});
  assign rem_nxt = ge ? W'(shifted - {1'b0, dvs_r}) : shifted[W-1:0];

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

endmodule

FILE: rtl/core/tsp_back.sv
module tsp_back
  import tsp_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int POSITION_SCALE = POSITION_SCALE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_valid,
  input  logic [3*SAMPLE_BITS+ENT_FIXED_W-1:0]   q_data,
  output logic                                   q_pop,
  tsp_out_if.source                              out_ch
);

  localparam int DW = SAMPLE_BITS + 2;

  // Reciprocal of the scale, exact floor division for any DW-bit sum
  localparam int SCALE_SH = DW + $clog2(POSITION_SCALE);
  localparam int RW       = DW + 1;
  localparam int PW       = DW + RW;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SCALE_SH) + 64'(POSITION_SCALE) - 64'd1) / 64'(POSITION_SCALE);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] drop;
    logic [SAMPLE_BITS-1:0] d0;
    logic [SAMPLE_BITS-1:0] d1;
    logic [NUM_CH-1:0]      mask;
    logic                   done;
    logic [CH_W-1:0]        next_ch;
  } tsp_ent_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCALE = 4'b0010,
    S_RATIO = 4'b0100,
    S_FIN   = 4'b1000
  } bk_state_t;

  tsp_ent_t               ent;
  bk_state_t              state_r, state_nxt;
  logic signed [POS_W-1:0] held_r;
  logic signed [POS_W-1:0] pos_r, pos_nxt;
  logic [NUM_CH-1:0]      mask_r;
  logic [CH_W-1:0]        next_r;
  logic [SAMPLE_BITS-1:0] drop_r;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic                   neg_r;
  logic [DW-1:0]          sum_r;

  logic                   out_vld_r;
  logic signed [POS_W-1:0] out_pos_r;
  logic [NUM_CH-1:0]      out_mask_r;
  logic                   out_upd_r;
  logic [CH_W-1:0]        out_next_r;
  logic [SAMPLE_BITS-1:0] out_drop_r;

  logic                   out_free;
  logic                   ld_out;
  logic                   ld_fin;
  logic                   latch;
  logic                   div_start;
  logic [DW-1:0]          div_a;
  logic [DW-1:0]          div_b;
  logic                   div_done;
  logic [DW-1:0]          div_quo;
  logic [DW-1:0]          sum;
  logic [PW-1:0]          scaled;
  logic [DW-1:0]          den;
  logic signed [POS_W-1:0] mag_c;
  logic signed [POS_W-1:0] ratio_pos;

  assign ent = q_data;

  assign out_ch.valid            = out_vld_r;
  assign out_ch.position         = out_pos_r;
  assign out_ch.press_mask       = out_mask_r;
  assign out_ch.position_updated = out_upd_r;
  assign out_ch.next_channel     = out_next_r;
  assign out_ch.channel_drop     = out_drop_r;

  assign out_free = !out_vld_r || out_ch.ready;

  // Drop sum at full width
  assign sum = DW'(ent.d0) + DW'(ent.d1) + DW'(ent.drop);

  // Divisor: latched sum over the scale, by reciprocal multiply
  assign scaled = PW'(sum_r) * PW'(RECIP);
  assign den    = DW'(scaled >> SCALE_SH);

  // Ratio result, clamped and signed
  assign mag_c = (div_quo > DW'(POSITION_SCALE)) ? POS_W'(POSITION_SCALE)
                                                 : POS_W'(div_quo);
  assign ratio_pos = neg_r ? -mag_c : mag_c;

  tsp_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer: plain samples pass; pressed closing samples scale, divide at most once
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    q_pop     = 1'b0;
    ld_out    = 1'b0;
    ld_fin    = 1'b0;
    latch     = 1'b0;
    div_start = 1'b0;
    div_a     = DW'(mag_r);
    div_b     = den;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (!ent.done) begin
            if (out_free) begin
              q_pop  = 1'b1;
              ld_out = 1'b1;
            end
          end else begin
            q_pop = 1'b1;
            latch = 1'b1;
            if (ent.mask == '0) begin
              pos_nxt   = '0;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_SCALE;
            end
          end
        end
      end
      S_SCALE: begin
        if (den == '0) begin
          pos_nxt   = held_r;
          state_nxt = S_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = S_RATIO;
        end
      end
      S_RATIO: begin
        if (div_done) begin
          pos_nxt   = ratio_pos;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ld_fin    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      held_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld_fin) begin
        held_r <= pos_r;
      end
      if (ld_out || ld_fin) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Closing-sample context and output register
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (latch) begin
      mask_r <= ent.mask;
      next_r <= ent.next_ch;
      drop_r <= ent.drop;
      sum_r  <= sum;
      neg_r  <= (ent.d0 > ent.drop);
      mag_r  <= (ent.drop >= ent.d0) ? ent.drop - ent.d0 : ent.d0 - ent.drop;
    end
    if (ld_out) begin
      out_pos_r  <= held_r;
      out_mask_r <= ent.mask;
      out_upd_r  <= 1'b0;
      out_next_r <= ent.next_ch;
      out_drop_r <= ent.drop;
    end else if (ld_fin) begin
      out_pos_r  <= pos_r;
      out_mask_r <= mask_r;
      out_upd_r  <= 1'b1;
      out_next_r <= next_r;
      out_drop_r <= drop_r;
    end
  end

endmodule

FILE: rtl/core/touch_slider_position_top.sv
// Flow: a sample that does not close a scan round passes through the queue into the
// output register; a round-closing sample with a press has its drop sum scaled by a
// reciprocal multiply, then one bit-serial divide forms the ratio.
// Samples transfer back to back until the 2-entry queue fills; the back end takes no
// new sample until the result of a closing sample is loaded.
// Reset (rst_n low, synchronous): channel 0, no press flags, position 0, thresholds 2000/500.
module touch_slider_position_top
  import tsp_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int POSITION_SCALE = POSITION_SCALE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  tsp_in_if.sink                 in_ch,
  tsp_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [SAMPLE_BITS-1:0] cfg_data
);

  localparam int ENT_W = 3 * SAMPLE_BITS + ENT_FIXED_W;

  logic             q_push;
  logic             q_ready;
  logic [ENT_W-1:0] q_wdata;
  logic             q_pop;
  logic             q_valid;
  logic [ENT_W-1:0] q_rdata;

  // Front: baseline subtract, hysteresis, scan sequencing
  tsp_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_ready  (q_ready)
  );

  // Queue between front and back
  tsp_fifo #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_data  (q_wdata),
    .wr_ready (q_ready),
    .rd_en    (q_pop),
    .rd_data  (q_rdata),
    .rd_valid (q_valid)
  );

  // Back: position update and result register
  tsp_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .POSITION_SCALE (POSITION_SCALE)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
